// File: rtl/spa_pkg.sv
// Shared types and constants for the slab pool allocator.
`timescale 1ns / 1ps

package spa_pkg;

    localparam int NUM_BLOCKS = 16;
    localparam int MAX_SLOTS  = 64;
    localparam int BLK_W      = $clog2(NUM_BLOCKS);
    localparam int SLOT_W     = $clog2(MAX_SLOTS);
    localparam int BPTR_W     = BLK_W + 1;
    localparam int SPTR_W     = SLOT_W + 1;
    localparam int SIDX_W     = BLK_W + SLOT_W;
    localparam int CNT_W      = 11;
    localparam int SPB_W      = 7;
    localparam int PADDR_W    = 3;

    localparam logic [BPTR_W-1:0] NO_BLOCK = BPTR_W'(NUM_BLOCKS);
    localparam logic [SPTR_W-1:0] NO_SLOT  = SPTR_W'(MAX_SLOTS);
    localparam logic [SPB_W-1:0]  SPB_RESET = 7'd10;
    localparam logic [SPB_W-1:0]  SPB_MAX   = SPB_W'(MAX_SLOTS);

    // Register index of slots_per_block.
    localparam logic [PADDR_W-3:0] REG_SPB = '0;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_NO_BLOCK = 2'd1;
    localparam logic [1:0] STATUS_BAD_REL  = 2'd2;

    typedef enum logic [1:0] {
        LIST_EMPTY   = 2'd0,
        LIST_PARTIAL = 2'd1,
        LIST_FULL    = 2'd2
    } list_t;

    typedef struct packed {
        logic [SPB_W-1:0]  free_slots;
        logic [SPB_W-1:0]  bump;
        logic [SPTR_W-1:0] fl_head;
        logic [BPTR_W-1:0] prev;
        logic [BPTR_W-1:0] next;
    } blk_rec_t;

    typedef struct packed {
        logic              in_use;
        logic [SPTR_W-1:0] fl_link;
    } slot_rec_t;

endpackage

// File: rtl/spa_cfg.sv
// Configuration register port holding slots_per_block.
`timescale 1ns / 1ps

module spa_cfg (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [spa_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        lock,
    output logic [spa_pkg::SPB_W-1:0]   spb
);
    import spa_pkg::*;

    logic [SPB_W-1:0] spb_reg;
    logic [SPB_W-1:0] spb_next;
    logic [SPB_W-1:0] wval;

    // Zero reads as one and anything above the slot limit saturates.
    always_comb begin
        wval = pwdata[SPB_W-1:0];
        if (wval == '0) begin
            wval = SPB_W'(1);
        end else if (wval > SPB_MAX) begin
            wval = SPB_MAX;
        end
        spb_next = spb_reg;
        if (psel && penable && pwrite && !lock && paddr[PADDR_W-1:2] == REG_SPB) begin
            spb_next = wval;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spb_reg <= SPB_RESET;
        end else begin
            spb_reg <= spb_next;
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[PADDR_W-1:2] == REG_SPB) ? {25'd0, spb_reg} : 32'd0;
    assign spb    = spb_reg;

endmodule

// File: rtl/slab_pool_allocator.sv
// Slab pool allocator top level: block and slot memories driven by a sequencer.
`timescale 1ns / 1ps
// Sequence: an allocate reads the block, picks a slot (reading it too when it comes off the
// free list) and passes ALLOCFIN; a release reads block and slot. Either runs a list move
// (MVP, MVN, MVH) each time the block changes list, then WB and RESP. A refused item (pool
// exhausted, bad release) goes to RESP from IDLE or after the block read. Throughput: one
// item at a time; the next is accepted after a result is loaded, later while m_ready is low.
// Reset: aresetn is synchronous and active low; a pass over every slot then clears slot memory.

module slab_pool_allocator (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_kind,
    input  logic [3:0]                  s_release_block,
    input  logic [5:0]                  s_release_slot,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [1:0]                  m_status,
    output logic [3:0]                  m_granted_block,
    output logic [5:0]                  m_granted_slot,
    output logic [10:0]                 m_used_count,
    output logic [10:0]                 m_free_count,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [spa_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import spa_pkg::*;

    // One-hot sequencer states.
    typedef enum logic [10:0] {
        ST_CLEAR    = 11'b000_0000_0001,
        ST_IDLE     = 11'b000_0000_0010,
        ST_BLKRD    = 11'b000_0000_0100,
        ST_SLOTSEL  = 11'b000_0000_1000,
        ST_SLOTRD   = 11'b000_0001_0000,
        ST_ALLOCFIN = 11'b000_0010_0000,
        ST_MVP      = 11'b000_0100_0000,
        ST_MVN      = 11'b000_1000_0000,
        ST_MVH      = 11'b001_0000_0000,
        ST_WB       = 11'b010_0000_0000,
        ST_RESP     = 11'b100_0000_0000
    } state_t;

    // Block memory write modes: whole record or one link field.
    typedef enum logic [1:0] {
        BW_NONE = 2'd0,
        BW_FULL = 2'd1,
        BW_PREV = 2'd2,
        BW_NEXT = 2'd3
    } bw_t;

    logic [SPB_W-1:0] spb;

    state_t            state_reg, state_next;
    logic              kind_reg, kind_next;
    logic [BLK_W-1:0]  blk_reg, blk_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic              create_reg, create_next;
    logic              move_reg, move_next;
    logic              slot_done_reg, slot_done_next;
    blk_rec_t          cur_reg, cur_next;
    list_t             from_reg, from_next;
    list_t             to_reg, to_next;
    logic [1:0]        status_reg, status_next;
    logic [BLK_W-1:0]  gb_reg, gb_next;
    logic [SLOT_W-1:0] gs_reg, gs_next;
    logic [CNT_W-1:0]  used_reg, used_next;
    logic [CNT_W-1:0]  free_reg, free_next;
    logic [BPTR_W-1:0] created_reg, created_next;
    logic [BPTR_W-1:0] he_reg, he_next;
    logic [BPTR_W-1:0] hp_reg, hp_next;
    logic [BPTR_W-1:0] hf_reg, hf_next;
    logic [SIDX_W-1:0] clr_reg, clr_next;
    logic              m_valid_reg, m_valid_next;
    logic [1:0]        m_status_reg;
    logic [BLK_W-1:0]  m_gb_reg;
    logic [SLOT_W-1:0] m_gs_reg;
    logic [CNT_W-1:0]  m_used_reg;
    logic [CNT_W-1:0]  m_free_reg;
    logic              m_load;

    // Block memory: one record per block, written only once a block is in use.
    blk_rec_t          blk_mem [NUM_BLOCKS];
    blk_rec_t          blk_rdata;
    logic [BLK_W-1:0]  blk_raddr;
    logic [BLK_W-1:0]  blk_waddr;
    blk_rec_t          blk_wdata;
    bw_t               blk_wmode;

    // Slot memory: in-use flag and free list link for every slot.
    slot_rec_t         slot_mem [NUM_BLOCKS*MAX_SLOTS];
    slot_rec_t         slot_rdata;
    logic [SIDX_W-1:0] slot_raddr;
    logic [SIDX_W-1:0] slot_waddr;
    slot_rec_t         slot_wdata;
    logic              slot_we;

    logic              accept;
    logic [BPTR_W-1:0] head_to;

    spa_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .lock    (created_reg != '0),
        .spb     (spb)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        case (blk_wmode)
            BW_FULL: blk_mem[blk_waddr]      <= blk_wdata;
            BW_PREV: blk_mem[blk_waddr].prev <= blk_wdata.prev;
            BW_NEXT: blk_mem[blk_waddr].next <= blk_wdata.next;
            default: ;
        endcase
        blk_rdata <= blk_mem[blk_raddr];
    end

    always_ff @(posedge aclk) begin
        if (slot_we) begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
        slot_rdata <= slot_mem[slot_raddr];
    end

    always_comb begin
        case (to_reg)
            LIST_EMPTY:   head_to = he_reg;
            LIST_PARTIAL: head_to = hp_reg;
            default:      head_to = hf_reg;
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        blk_next       = blk_reg;
        slot_next      = slot_reg;
        create_next    = create_reg;
        move_next      = move_reg;
        slot_done_next = slot_done_reg;
        cur_next       = cur_reg;
        from_next      = from_reg;
        to_next        = to_reg;
        status_next    = status_reg;
        gb_next        = gb_reg;
        gs_next        = gs_reg;
        used_next      = used_reg;
        free_next      = free_reg;
        created_next   = created_reg;
        he_next        = he_reg;
        hp_next        = hp_reg;
        hf_next        = hf_reg;
        clr_next       = clr_reg;
        m_load         = 1'b0;

        blk_raddr  = blk_reg;
        blk_waddr  = blk_reg;
        blk_wdata  = cur_reg;
        blk_wmode  = BW_NONE;
        slot_raddr = {blk_reg, slot_reg};
        slot_waddr = {blk_reg, slot_reg};
        slot_wdata = '{in_use: 1'b0, fl_link: '0};
        slot_we    = 1'b0;

        case (state_reg)
            ST_CLEAR: begin
                slot_we    = 1'b1;
                slot_waddr = clr_reg;
                clr_next   = clr_reg + SIDX_W'(1);
                if (clr_reg == '1) begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE: begin
                if (accept) begin
                    kind_next      = s_kind;
                    status_next    = STATUS_OK;
                    gb_next        = '0;
                    gs_next        = '0;
                    slot_done_next = 1'b0;
                    create_next    = 1'b0;
                    move_next      = 1'b0;
                    state_next     = ST_BLKRD;
                    if (!s_kind) begin
                        // Partial head first, then empty head, then a fresh block.
                        if (!hp_reg[BLK_W]) begin
                            blk_next = hp_reg[BLK_W-1:0];
                        end else if (!he_reg[BLK_W]) begin
                            blk_next  = he_reg[BLK_W-1:0];
                            move_next = 1'b1;
                        end else if (!created_reg[BLK_W]) begin
                            blk_next    = created_reg[BLK_W-1:0];
                            move_next   = 1'b1;
                            create_next = 1'b1;
                        end else begin
                            status_next = STATUS_NO_BLOCK;
                            state_next  = ST_RESP;
                        end
                    end else begin
                        blk_next  = s_release_block;
                        slot_next = s_release_slot;
                        if ({1'b0, s_release_block} >= created_reg ||
                            {1'b0, s_release_slot} >= spb) begin
                            status_next = STATUS_BAD_REL;
                            state_next  = ST_RESP;
                        end
                    end
                    blk_raddr  = blk_next;
                    slot_raddr = {s_release_block, s_release_slot};
                end
            end

            ST_BLKRD: begin
                if (!kind_reg) begin
                    if (create_reg) begin
                        cur_next = '{free_slots: spb, bump: '0, fl_head: NO_SLOT,
                                     prev: NO_BLOCK, next: NO_BLOCK};
                        created_next = created_reg + BPTR_W'(1);
                        free_next    = free_reg + CNT_W'(spb);
                    end else begin
                        cur_next = blk_rdata;
                    end
                    if (move_reg) begin
                        from_next  = LIST_EMPTY;
                        to_next    = LIST_PARTIAL;
                        state_next = ST_MVP;
                    end else begin
                        state_next = ST_SLOTSEL;
                    end
                end else if (!slot_rdata.in_use) begin
                    status_next = STATUS_BAD_REL;
                    state_next  = ST_RESP;
                end else begin
                    // Push the slot onto the block's free list.
                    slot_we             = 1'b1;
                    slot_wdata.fl_link  = blk_rdata.fl_head;
                    cur_next            = blk_rdata;
                    cur_next.fl_head    = {1'b0, slot_reg};
                    cur_next.free_slots = blk_rdata.free_slots + SPB_W'(1);
                    used_next           = used_reg - CNT_W'(1);
                    free_next           = free_reg + CNT_W'(1);
                    slot_done_next      = 1'b1;
                    state_next          = ST_WB;
                    if (cur_next.free_slots == spb) begin
                        // Block is empty again: reset it and file it as empty.
                        cur_next.fl_head = NO_SLOT;
                        cur_next.bump    = '0;
                        from_next  = (blk_rdata.free_slots == '0) ? LIST_FULL : LIST_PARTIAL;
                        to_next    = LIST_EMPTY;
                        state_next = ST_MVP;
                    end else if (blk_rdata.free_slots == '0) begin
                        from_next  = LIST_FULL;
                        to_next    = LIST_PARTIAL;
                        state_next = ST_MVP;
                    end
                end
            end

            ST_SLOTSEL: begin
                slot_raddr = {blk_reg, cur_reg.fl_head[SLOT_W-1:0]};
                if (!cur_reg.fl_head[SLOT_W]) begin
                    state_next = ST_SLOTRD;
                end else begin
                    slot_next     = cur_reg.bump[SLOT_W-1:0];
                    cur_next.bump = cur_reg.bump + SPB_W'(1);
                    state_next    = ST_ALLOCFIN;
                end
            end

            ST_SLOTRD: begin
                slot_next        = cur_reg.fl_head[SLOT_W-1:0];
                cur_next.fl_head = slot_rdata.fl_link;
                state_next       = ST_ALLOCFIN;
            end

            ST_ALLOCFIN: begin
                slot_we             = 1'b1;
                slot_wdata.in_use   = 1'b1;
                cur_next.free_slots = cur_reg.free_slots - SPB_W'(1);
                used_next           = used_reg + CNT_W'(1);
                free_next           = free_reg - CNT_W'(1);
                gb_next             = blk_reg;
                gs_next             = slot_reg;
                slot_done_next      = 1'b1;
                if (cur_reg.free_slots == SPB_W'(1)) begin
                    from_next  = LIST_PARTIAL;
                    to_next    = LIST_FULL;
                    state_next = ST_MVP;
                end else begin
                    state_next = ST_WB;
                end
            end

            ST_MVP: begin
                // Unlink, predecessor side.
                if (!cur_reg.prev[BLK_W]) begin
                    blk_waddr      = cur_reg.prev[BLK_W-1:0];
                    blk_wdata.next = cur_reg.next;
                    blk_wmode      = BW_NEXT;
                end else begin
                    case (from_reg)
                        LIST_EMPTY:   he_next = cur_reg.next;
                        LIST_PARTIAL: hp_next = cur_reg.next;
                        default:      hf_next = cur_reg.next;
                    endcase
                end
                state_next = ST_MVN;
            end

            ST_MVN: begin
                // Unlink, successor side.
                if (!cur_reg.next[BLK_W]) begin
                    blk_waddr      = cur_reg.next[BLK_W-1:0];
                    blk_wdata.prev = cur_reg.prev;
                    blk_wmode      = BW_PREV;
                end
                state_next = ST_MVH;
            end

            ST_MVH: begin
                // Push at the head of the target list.
                if (!head_to[BLK_W]) begin
                    blk_waddr      = head_to[BLK_W-1:0];
                    blk_wdata.prev = {1'b0, blk_reg};
                    blk_wmode      = BW_PREV;
                end
                cur_next.prev = NO_BLOCK;
                cur_next.next = head_to;
                case (to_reg)
                    LIST_EMPTY:   he_next = {1'b0, blk_reg};
                    LIST_PARTIAL: hp_next = {1'b0, blk_reg};
                    default:      hf_next = {1'b0, blk_reg};
                endcase
                state_next = slot_done_reg ? ST_WB : ST_SLOTSEL;
            end

            ST_WB: begin
                blk_wmode  = BW_FULL;
                state_next = ST_RESP;
            end

            ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_load     = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (m_load) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            created_reg <= '0;
            used_reg    <= '0;
            free_reg    <= '0;
            he_reg      <= NO_BLOCK;
            hp_reg      <= NO_BLOCK;
            hf_reg      <= NO_BLOCK;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            created_reg <= created_next;
            used_reg    <= used_next;
            free_reg    <= free_next;
            he_reg      <= he_next;
            hp_reg      <= hp_next;
            hf_reg      <= hf_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg      <= kind_next;
        blk_reg       <= blk_next;
        slot_reg      <= slot_next;
        create_reg    <= create_next;
        move_reg      <= move_next;
        slot_done_reg <= slot_done_next;
        cur_reg       <= cur_next;
        from_reg      <= from_next;
        to_reg        <= to_next;
        status_reg    <= status_next;
        gb_reg        <= gb_next;
        gs_reg        <= gs_next;
        if (m_load) begin
            m_status_reg <= status_reg;
            m_gb_reg     <= gb_reg;
            m_gs_reg     <= gs_reg;
            m_used_reg   <= used_reg;
            m_free_reg   <= free_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_granted_block = m_gb_reg;
    assign m_granted_slot  = m_gs_reg;
    assign m_used_count    = m_used_reg;
    assign m_free_count    = m_free_reg;

endmodule

// File: dv/tb_slab_pool_allocator.sv
// Self-checking testbench for the slab pool allocator.
`timescale 1ns / 1ps

module tb_slab_pool_allocator;
    import spa_pkg::*;

    // The two kinds of request on the input channel.
    localparam logic KIND_ALLOC   = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;
    localparam logic [PADDR_W-1:0] ADDR_SPB = {REG_SPB, 2'b00};
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 16;
    localparam int LONG_HOLD    = 400;

    typedef struct packed {
        logic       kind;
        logic [3:0] blk;
        logic [5:0] slot;
    } request_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  gblk;
        logic [5:0]  gslot;
        logic [10:0] used;
        logic [10:0] free;
    } grant_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_kind = 1'b0;
    logic [3:0]  s_release_block = '0;
    logic [5:0]  s_release_slot = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic [3:0]  m_granted_block;
    logic [5:0]  m_granted_slot;
    logic [10:0] m_used_count;
    logic [10:0] m_free_count;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    slab_pool_allocator dut (.*);

    initial begin
        forever #10 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Allocator shadow state. Lists are doubly linked through blk_prev and
    // blk_next, with NUM_BLOCKS standing for "no block" and MAX_SLOTS for
    // an empty per-block free list.
    // ------------------------------------------------------------------
    int unsigned slots_cfg;
    int unsigned blocks_made;
    int unsigned used_total;
    int unsigned free_total;
    int unsigned blk_free [NUM_BLOCKS];
    int unsigned blk_bump [NUM_BLOCKS];
    int unsigned blk_fl_head [NUM_BLOCKS];
    int unsigned blk_prev [NUM_BLOCKS];
    int unsigned blk_next [NUM_BLOCKS];
    list_t       blk_list [NUM_BLOCKS];
    int unsigned slot_link [NUM_BLOCKS*MAX_SLOTS];
    bit          slot_taken [NUM_BLOCKS*MAX_SLOTS];
    int unsigned list_head [3];

    // Handles (block * MAX_SLOTS + slot) that are allocated right now, used
    // to build well-formed releases.
    int unsigned live_handles [$];
    request_t    pending_reqs [$];
    grant_t      expected_grants [$];

    int unsigned n_alloc_ok, n_exhausted, n_release_ok, n_bad_release;
    int unsigned n_checked, n_mismatch;
    int unsigned cycle_count;
    bit          long_hold_done;

    function automatic void shadow_reset();
        slots_cfg = 10;
        blocks_made = 0;
        used_total = 0;
        free_total = 0;
        for (int i = 0; i < NUM_BLOCKS; i++) begin
            blk_free[i] = 0;
            blk_bump[i] = 0;
            blk_fl_head[i] = MAX_SLOTS;
            blk_prev[i] = NUM_BLOCKS;
            blk_next[i] = NUM_BLOCKS;
            blk_list[i] = LIST_EMPTY;
        end
        for (int i = 0; i < NUM_BLOCKS*MAX_SLOTS; i++) begin
            slot_link[i] = 0;
            slot_taken[i] = 1'b0;
        end
        for (int i = 0; i < 3; i++) list_head[i] = NUM_BLOCKS;
    endfunction

    // The size register is frozen once the first block has been brought in.
    function automatic void shadow_write_spb(logic [31:0] value);
        int unsigned v;
        v = value[6:0];
        if (blocks_made == 0) begin
            if (v == 0) v = 1;
            if (v > MAX_SLOTS) v = MAX_SLOTS;
            slots_cfg = v;
        end
    endfunction

    function automatic void block_unlink(int unsigned b);
        int unsigned p, n;
        p = blk_prev[b];
        n = blk_next[b];
        if (p < NUM_BLOCKS) blk_next[p] = n;
        else list_head[blk_list[b]] = n;
        if (n < NUM_BLOCKS) blk_prev[n] = p;
        blk_prev[b] = NUM_BLOCKS;
        blk_next[b] = NUM_BLOCKS;
    endfunction

    function automatic void block_push(int unsigned b, list_t l);
        int unsigned h;
        h = list_head[l];
        blk_prev[b] = NUM_BLOCKS;
        blk_next[b] = h;
        if (h < NUM_BLOCKS) blk_prev[h] = b;
        list_head[l] = b;
        blk_list[b] = l;
    endfunction

    function automatic void block_move(int unsigned b, list_t l);
        block_unlink(b);
        block_push(b, l);
    endfunction

    // Works out the grant for one request and advances the shadow state.
    function automatic grant_t allocator_predict(request_t req);
        grant_t g;
        int unsigned b, s, idx;
        bit ok;
        g = '0;
        g.status = STATUS_OK;
        if (req.kind == KIND_ALLOC) begin
            ok = 1'b1;
            b = list_head[LIST_PARTIAL];
            if (b >= NUM_BLOCKS) begin
                b = list_head[LIST_EMPTY];
                if (b >= NUM_BLOCKS) begin
                    if (blocks_made < NUM_BLOCKS) begin
                        b = blocks_made;
                        blocks_made++;
                        blk_free[b] = slots_cfg;
                        blk_bump[b] = 0;
                        blk_fl_head[b] = MAX_SLOTS;
                        free_total += slots_cfg;
                        block_push(b, LIST_EMPTY);
                    end else begin
                        ok = 1'b0;
                    end
                end
                if (ok) block_move(b, LIST_PARTIAL);
            end
            if (ok) begin
                s = blk_fl_head[b];
                if (s < MAX_SLOTS) begin
                    blk_fl_head[b] = slot_link[b*MAX_SLOTS + s];
                end else begin
                    s = blk_bump[b];
                    blk_bump[b]++;
                end
                slot_taken[b*MAX_SLOTS + s] = 1'b1;
                blk_free[b]--;
                free_total--;
                used_total++;
                if (blk_free[b] == 0) block_move(b, LIST_FULL);
                g.gblk = b[3:0];
                g.gslot = s[5:0];
                live_handles.push_back(b*MAX_SLOTS + s);
                n_alloc_ok++;
            end else begin
                g.status = STATUS_NO_BLOCK;
                n_exhausted++;
            end
        end else begin
            b = req.blk;
            s = req.slot;
            idx = b*MAX_SLOTS + s;
            if (b >= blocks_made || s >= slots_cfg || !slot_taken[idx]) begin
                g.status = STATUS_BAD_REL;
                n_bad_release++;
            end else begin
                slot_link[idx] = blk_fl_head[b];
                blk_fl_head[b] = s;
                slot_taken[idx] = 1'b0;
                used_total--;
                free_total++;
                blk_free[b]++;
                // A block that drains completely is reset; with one slot per
                // block this takes it straight from full to empty.
                if (blk_free[b] == slots_cfg) begin
                    block_move(b, LIST_EMPTY);
                    blk_fl_head[b] = MAX_SLOTS;
                    blk_bump[b] = 0;
                end else if (blk_free[b] == 1) begin
                    block_move(b, LIST_PARTIAL);
                end
                foreach (live_handles[i])
                    if (live_handles[i] == idx) begin
                        live_handles.delete(i);
                        break;
                    end
                n_release_ok++;
            end
        end
        g.used = used_total[10:0];
        g.free = free_total[10:0];
        return g;
    endfunction

    // Requests are predicted as they are queued; the block handles them in
    // the same order, so the expectation queue lines up with the results.
    function automatic void queue_request(logic kind, int unsigned b, int unsigned s);
        request_t r;
        r.kind = kind;
        r.blk = b[3:0];
        r.slot = s[5:0];
        pending_reqs.push_back(r);
        expected_grants.push_back(allocator_predict(r));
    endfunction

    function automatic void queue_live_release();
        int unsigned k, h;
        k = $urandom_range(0, live_handles.size() - 1);
        h = live_handles[k];
        queue_request(KIND_RELEASE, h / MAX_SLOTS, h % MAX_SLOTS);
    endfunction

    // Mostly back to back, sometimes a short pause, rarely a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // ------------------------------------------------------------------
    // Driver: presents queued requests, holding each until it is taken.
    // ------------------------------------------------------------------
    int unsigned send_gap;
    always @(posedge aclk) begin
        request_t r;
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap = 0;
        end else if (!s_valid || s_ready) begin
            if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                r = pending_reqs.pop_front();
                s_kind <= r.kind;
                s_release_block <= r.blk;
                s_release_slot <= r.slot;
                s_valid <= 1'b1;
                send_gap = pick_gap();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result side: random back-pressure plus one long hold-off so that the
    // block backs up and stops taking requests while the driver keeps going.
    // ------------------------------------------------------------------
    int unsigned recv_gap;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            recv_gap = 0;
        end else if (!long_hold_done && n_checked >= 150) begin
            long_hold_done = 1'b1;
            recv_gap = LONG_HOLD;
            m_ready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if (m_valid && m_ready) recv_gap = pick_gap();
        end
    end

    // Monitor: each accepted result is checked against the oldest expectation.
    always @(posedge aclk) begin
        grant_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_grants.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("ERROR: unexpected result status=%0d blk=%0d slot=%0d",
                             m_status, m_granted_block, m_granted_slot);
            end else begin
                want = expected_grants.pop_front();
                if (m_status !== want.status || m_granted_block !== want.gblk ||
                    m_granted_slot !== want.gslot || m_used_count !== want.used ||
                    m_free_count !== want.free) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display({"ERROR: result %0d expected st=%0d blk=%0d slot=%0d ",
                                  "used=%0d free=%0d, got st=%0d blk=%0d slot=%0d ",
                                  "used=%0d free=%0d"}, n_checked,
                                 want.status, want.gblk, want.gslot, want.used,
                                 want.free, m_status, m_granted_block, m_granted_slot,
                                 m_used_count, m_free_count);
                end
            end
            n_checked++;
        end
    end

    // Watchdog on total run length.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("ERROR: timeout with %0d results outstanding", expected_grants.size());
            $display("** slab_pool_allocator: FAILED **");
            $finish;
        end
    end

    // Register write: setup cycle, then access cycle.
    task automatic apb_write_spb(logic [31:0] value);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_SPB;
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        shadow_write_spb(value);
    endtask

    // Waits until every queued request has produced its result, then lets the
    // block settle for its worst-case latency.
    task automatic wait_drained();
        while (pending_reqs.size() > 0 || expected_grants.size() > 0 || s_valid)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------
    int unsigned alloc_pct [5] = '{70, 95, 20, 60, 10};
    initial begin
        int unsigned run_spb;
        shadow_reset();
        n_alloc_ok = 0;
        n_exhausted = 0;
        n_release_ok = 0;
        n_bad_release = 0;
        n_checked = 0;
        n_mismatch = 0;
        cycle_count = 0;
        long_hold_done = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // While no block is in use the size register takes writes: zero
        // is raised to one and values past the maximum are capped. Upper
        // bits of the write data must be ignored.
        apb_write_spb(32'h0);
        apb_write_spb(32'hFFFF_FF7F);
        apb_write_spb(32'd64);
        run_spb = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 6);
        apb_write_spb(32'hABCD_0000 | run_spb);

        // Directed part: release with nothing allocated, single allocate,
        // release that empties the block, double release, slot past the
        // block size, block never brought in, then a run across blocks
        // filling them and a release that reuses the free list.
        queue_request(KIND_RELEASE, 15, 63);
        queue_request(KIND_ALLOC, 0, 0);
        queue_request(KIND_RELEASE, 0, 0);
        queue_request(KIND_RELEASE, 0, 0);
        queue_request(KIND_ALLOC, 7, 42);
        queue_request(KIND_RELEASE, 0, run_spb);
        queue_request(KIND_RELEASE, 5, 0);
        for (int i = 0; i < 2*run_spb + 1 && i < 12; i++)
            queue_request(KIND_ALLOC, 0, 0);
        queue_request(KIND_RELEASE, 1, 0);
        queue_request(KIND_RELEASE, 0, run_spb - 1);
        queue_request(KIND_ALLOC, 0, 0);
        queue_request(KIND_ALLOC, 0, 0);
        wait_drained();

        // Random phases, each leaning toward filling or draining the pool.
        for (int ph = 0; ph < 5; ph++) begin
            for (int i = 0; i < 100; i++) begin
                int unsigned r;
                r = $urandom_range(0, 99);
                if (r < 10)
                    queue_request(KIND_RELEASE, $urandom_range(0, 15), $urandom_range(0, 63));
                else if (r < 10 + (alloc_pct[ph] * 90) / 100 || live_handles.size() == 0)
                    queue_request(KIND_ALLOC, $urandom_range(0, 15), $urandom_range(0, 63));
                else
                    queue_live_release();
            end
            wait_drained();
            // Writes once blocks are in use must leave the size unchanged.
            apb_write_spb((ph % 2) ? 32'd1 : 32'd127);
        end

        // Free everything that is still held.
        while (live_handles.size() > 0) queue_live_release();
        wait_drained();

        $display("Run with %0d slots per block: %0d grants, %0d exhausted, %0d releases,",
                 slots_cfg, n_alloc_ok, n_exhausted, n_release_ok);
        $display("%0d rejected releases, %0d results checked, %0d mismatches.",
                 n_bad_release, n_checked, n_mismatch);
        if (n_mismatch == 0 && expected_grants.size() == 0)
            $display("** slab_pool_allocator: PASSED **");
        else
            $display("** slab_pool_allocator: FAILED **");
        $finish;
    end

endmodule

// File: slab_pool_allocator.f
rtl/spa_pkg.sv
rtl/spa_cfg.sv
rtl/slab_pool_allocator.sv
dv/tb_slab_pool_allocator.sv
